>>> hdl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SARD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SARD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> hdl/sard_pkg.sv
// Types and constants shared by the six-axis report deframer.
`default_nettype none

package sard_pkg;

   localparam int PAYLOAD_LEN = 12;
   localparam int POS_WIDTH   = 4;
   localparam int SUM_WIDTH   = 14;
   localparam int RCV_WIDTH   = 16;
   localparam int AXIS_WIDTH  = 16;

   localparam logic [7:0] START_MARK  = 8'h96;
   localparam logic [7:0] END_MARK    = 8'h8D;
   localparam logic [7:0] REQUEST_CMD = 8'hAC;

   localparam logic [POS_WIDTH-1:0] POS_CHECK_HI = POS_WIDTH'(PAYLOAD_LEN);
   localparam logic [POS_WIDTH-1:0] POS_MAX      = {POS_WIDTH{1'b1}};

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 14;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_BUDGET = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AXIS_OFFSET = 1'd1;
   localparam logic [7:0]  BYTE_BUDGET_RESET = 8'd15;
   localparam logic [13:0] AXIS_OFFSET_RESET = 14'd8192;

   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_BYTE    = 1'b1;

   localparam logic KIND_CMD    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
   localparam logic [1:0] STATUS_NO_START = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic                         result_kind;
      logic [7:0]                   tx_byte;
      logic [1:0]                   status;
      logic signed [AXIS_WIDTH-1:0] axis_x;
      logic signed [AXIS_WIDTH-1:0] axis_y;
      logic signed [AXIS_WIDTH-1:0] axis_z;
      logic signed [AXIS_WIDTH-1:0] tilt_x;
      logic signed [AXIS_WIDTH-1:0] tilt_y;
      logic signed [AXIS_WIDTH-1:0] twist;
   } rsp_payload_type;

   // one classified result waiting for the back end
   typedef struct packed {
      logic                              kind;
      logic [1:0]                        status;
      logic [PAYLOAD_LEN-1:0][7:0]       bytes;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

>>> hdl/sard_front.sv
// Front end: accepts items, tracks the frame and classifies each result.
`default_nettype none

module sard_front import sard_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   input  wire logic [7:0]      byte_budget,
   input  wire qstat_type       q_status,
   output logic                 push,
   output rec_type              push_rec
);

   logic                         open_ff,  open_in;
   logic                         start_ff, start_in;
   logic [7:0]                   spent_ff, spent_in;
   logic [POS_WIDTH-1:0]         pos_ff,   pos_in;
   logic [PAYLOAD_LEN-1:0][7:0]  store_ff, store_in;
   logic [SUM_WIDTH-1:0]         run_ff,   run_in;
   logic [RCV_WIDTH-1:0]         rcv_ff,   rcv_in;

   logic       accept;
   logic       is_cmd;
   logic       end_hit;
   logic [7:0] b;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_payload.rx_byte;

   always_comb begin
      open_in  = open_ff;
      start_in = start_ff;
      spent_in = spent_ff;
      pos_in   = pos_ff;
      store_in = store_ff;
      run_in   = run_ff;
      rcv_in   = rcv_ff;
      push     = 1'b0;
      is_cmd   = 1'b0;
      end_hit  = 1'b0;
      if (accept) begin
         if (req_payload.mode == MODE_REQUEST) begin
            open_in  = 1'b1;
            start_in = 1'b0;
            spent_in = '0;
            pos_in   = '0;
            store_in = '0;
            run_in   = '0;
            rcv_in   = '0;
            push     = 1'b1;
            is_cmd   = 1'b1;
         end else if (open_ff) begin
            if (b == START_MARK) begin
               // repeated start keeps position and stored payload
               start_in = 1'b1;
               run_in   = SUM_WIDTH'(START_MARK);
               spent_in = '0;
            end else begin
               if (start_ff) begin
                  if (b == END_MARK) begin
                     end_hit = 1'b1;
                     push    = 1'b1;
                     open_in = 1'b0;
                  end else begin
                     if (pos_ff < POS_CHECK_HI) begin
                        store_in[pos_ff] = b;
                        run_in = run_ff + {{(SUM_WIDTH-8){1'b0}}, b};
                     end else if (pos_ff == POS_CHECK_HI) begin
                        rcv_in = {1'b0, b, 7'b0};
                     end else begin
                        rcv_in = rcv_ff + {{(RCV_WIDTH-8){1'b0}}, b};
                     end
                     if (pos_ff != POS_MAX) begin
                        pos_in = pos_ff + POS_WIDTH'(1);
                     end
                  end
               end
               // budget check runs after the byte is taken in
               if (!end_hit) begin
                  if (spent_ff >= byte_budget) begin
                     push    = 1'b1;
                     open_in = 1'b0;
                  end else begin
                     spent_in = spent_ff + 8'd1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      push_rec.bytes = store_in;
      if (is_cmd) begin
         push_rec.kind   = KIND_CMD;
         push_rec.status = STATUS_GOOD;
      end else begin
         push_rec.kind = KIND_REPORT;
         if (!start_ff) begin
            push_rec.status = STATUS_NO_START;
         end else if (rcv_in != {{(RCV_WIDTH-SUM_WIDTH){1'b0}}, run_in}) begin
            push_rec.status = STATUS_BAD_SUM;
         end else begin
            push_rec.status = STATUS_GOOD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         start_ff <= 1'b0;
         spent_ff <= '0;
         pos_ff   <= '0;
         store_ff <= '0;
         run_ff   <= '0;
         rcv_ff   <= '0;
      end else begin
         open_ff  <= open_in;
         start_ff <= start_in;
         spent_ff <= spent_in;
         pos_ff   <= pos_in;
         store_ff <= store_in;
         run_ff   <= run_in;
         rcv_ff   <= rcv_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sard_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module sard_queue import sard_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rec_type push_rec,
   input  wire logic    pop,
   output rec_type      head,
   output qstat_type    q_status
);

   rec_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push;
   logic       do_pop;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/sard_back.sv
// Back end: decodes the axes and holds the result register.
`default_nettype none

module sard_back import sard_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rec_type      head,
   input  wire qstat_type    q_status,
   input  wire logic [13:0]  axis_offset,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_payload_type   rsp_payload
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic            decode_on;

   // byte pair n sits at bytes[2n] (shifted up by seven bits) and bytes[2n+1]
   function automatic logic [AXIS_WIDTH-1:0] axis_decode(
      input logic [7:0]  hi,
      input logic [7:0]  lo,
      input logic [13:0] offset
   );
      logic [AXIS_WIDTH-1:0] raw;
      raw = {1'b0, hi, 7'b0} + {8'b0, lo};
      return raw - {2'b0, offset};
   endfunction

   assign pop       = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign decode_on = (head.kind == KIND_REPORT) && (head.status == STATUS_GOOD);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in             = '0;
         rsp_payload_in.result_kind = head.kind;
         rsp_payload_in.status      = head.status;
         if (head.kind == KIND_CMD) begin
            rsp_payload_in.tx_byte = REQUEST_CMD;
         end
         if (decode_on) begin
            rsp_payload_in.axis_x = axis_decode(head.bytes[0],  head.bytes[1],  axis_offset);
            rsp_payload_in.axis_z = axis_decode(head.bytes[2],  head.bytes[3],  axis_offset);
            rsp_payload_in.axis_y = axis_decode(head.bytes[4],  head.bytes[5],  axis_offset);
            rsp_payload_in.tilt_y = axis_decode(head.bytes[6],  head.bytes[7],  axis_offset);
            rsp_payload_in.twist  = axis_decode(head.bytes[8],  head.bytes[9],  axis_offset);
            rsp_payload_in.tilt_x = axis_decode(head.bytes[10], head.bytes[11], axis_offset);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

>>> hdl/six_axis_report_deframer_core.sv
// Six-axis report deframer, top level.
// Takes one item per clock while req_stall is low: a request (answered with command
// byte 0xAC) or one received serial byte, which is deframed into a single report after
// the end marker or when the byte budget runs out. The front end handles each item in
// the cycle it is taken; results are written into a two-entry queue and from there into
// the registered output, so the block sustains one item per cycle while req_stall is
// low. req_stall rises only when the queue holds two results that the output side has
// not taken. Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none
`include "assert_macros.svh"

module six_axis_report_deframer_core import sard_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_payload_type            req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_payload_type                 rsp_payload,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [7:0]  budget_ff, budget_in;
   logic [13:0] offset_ff, offset_in;
   logic        push;
   logic        pop;
   rec_type     push_rec;
   rec_type     head;
   qstat_type   q_status;

   always_comb begin
      budget_in = budget_ff;
      offset_in = offset_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BYTE_BUDGET: budget_in = csr_wdata[7:0];
            CSR_AXIS_OFFSET: offset_in = csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BYTE_BUDGET_RESET;
         offset_ff <= AXIS_OFFSET_RESET;
      end else begin
         budget_ff <= budget_in;
         offset_ff <= offset_in;
      end
   end

   sard_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .byte_budget (budget_ff),
      .q_status    (q_status),
      .push        (push),
      .push_rec    (push_rec)
   );

   sard_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   sard_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .axis_offset (offset_ff),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `SARD_ASSERT(a_cmd_shape, rsp_valid && (rsp_payload.result_kind == KIND_CMD) |-> (rsp_payload.tx_byte == REQUEST_CMD) && (rsp_payload.status == STATUS_GOOD), "command transfer malformed")
   `SARD_ASSERT(a_fault_zero, rsp_valid && (rsp_payload.status != STATUS_GOOD) |-> (rsp_payload.axis_x == '0) && (rsp_payload.twist == '0) && (rsp_payload.tilt_x == '0), "faulted report carries axes")
   `SARD_ASSERT(a_req_queued, req_valid && !req_stall && (req_payload.mode == MODE_REQUEST) |=> !q_status.empty, "request result not queued")
   `SARD_ASSERT_ALWAYS(a_no_push_full, push |-> !q_status.full, "push into full queue")

endmodule

`default_nettype wire
